// ===== sv/psds_pkg.sv =====
// Package: shared types, codes and defaults for the parity-split dual stack.
`timescale 1ns / 1ps

package psds_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_READ = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    sel;
        data_t   value;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== sv/parity_split_dual_stack_top.sv =====
// Top level: parity-steered dual LIFO stack with a queued command front end.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  command   | start / busy        | operation, which_stack, value
//  result    | valid (strobe)      | status, stack_id, data, data_valid,
//            |                     | is_empty, is_full, last
//
// A command is transferred when start is high and busy is low; busy means the
// two-entry command queue is full. A push or a pop gives one result; a read-out
// gives N results for N stored elements, one element per cycle from the stack
// memory read port, and a single result on an empty stack.
// Each result is on the ports for one cycle with valid high; the receiver
// cannot stall. Reset is asynchronous, active low; counts clear, stores do not.
`timescale 1ns / 1ps

module parity_split_dual_stack_top #(
    parameter int DEPTH = psds_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      operation,
    input  logic            which_stack,
    input  psds_pkg::data_t value,
    output logic            valid,
    output logic [1:0]      status,
    output logic            stack_id,
    output psds_pkg::data_t data,
    output logic            data_valid,
    output logic            is_empty,
    output logic            is_full,
    output logic            last
);
    import psds_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head;
    logic      push;
    logic      pop;

    psds_front u_front (
        .start       (start),
        .operation   (operation),
        .which_stack (which_stack),
        .value       (value),
        .q_status    (q_status),
        .busy        (busy),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    psds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    psds_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .valid      (valid),
        .status     (status),
        .stack_id   (stack_id),
        .data       (data),
        .data_valid (data_valid),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .last       (last)
    );

endmodule

// ===== sv/psds_front.sv =====
// Front end: takes commands, picks the target stack, drops unused opcodes.
`timescale 1ns / 1ps

module psds_front (
    input  logic               start,
    input  logic [1:0]         operation,
    input  logic               which_stack,
    input  psds_pkg::data_t    value,
    input  psds_pkg::q_status_t q_status,
    output logic               busy,
    output logic               push,
    output psds_pkg::cmd_t     push_cmd
);
    import psds_pkg::*;

    logic accept;

    assign busy   = q_status.full;
    assign accept = start && !q_status.full;

    always_comb
    begin
        push           = 1'b0;
        push_cmd.op    = CMD_PUSH;
        push_cmd.sel   = which_stack;
        push_cmd.value = value;
        case (operation)
            OP_PUSH:
            begin
                push         = accept;
                push_cmd.op  = CMD_PUSH;
                push_cmd.sel = value[0];
            end
            OP_POP:
            begin
                push        = accept;
                push_cmd.op = CMD_POP;
            end
            OP_READ:
            begin
                push        = accept;
                push_cmd.op = CMD_READ;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/psds_queue.sv =====
// Command queue between the front end and the stack engine.
`timescale 1ns / 1ps

module psds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psds_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output psds_pkg::cmd_t      head,
    output psds_pkg::q_status_t status
);
    import psds_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/psds_back.sv =====
// Stack engine: two LIFO memories, their counts and the result registers.
`timescale 1ns / 1ps

module psds_back #(
    parameter int DEPTH = psds_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psds_pkg::cmd_t      head,
    input  psds_pkg::q_status_t q_status,
    output logic                pop,
    output logic                valid,
    output logic [1:0]          status,
    output logic                stack_id,
    output psds_pkg::data_t     data,
    output logic                data_valid,
    output logic                is_empty,
    output logic                is_full,
    output logic                last
);
    import psds_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_EXEC      = 4'b0010,
        ST_POP_OUT   = 4'b0100,
        ST_RD_STREAM = 4'b1000
    } back_state_t;

    back_state_t    state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [CW-1:0]  even_cnt_reg, even_cnt_next;
    logic [CW-1:0]  odd_cnt_reg, odd_cnt_next;
    logic [AW-1:0]  idx_reg, idx_next;
    data_t          even_mem_reg [DEPTH];
    data_t          odd_mem_reg [DEPTH];
    data_t          rd_data_reg;

    logic           valid_reg, valid_next;
    logic [1:0]     status_reg, status_next;
    logic           stack_id_reg, stack_id_next;
    data_t          data_reg, data_next;
    logic           data_valid_reg, data_valid_next;
    logic           is_empty_reg, is_empty_next;
    logic           is_full_reg, is_full_next;
    logic           last_reg, last_next;

    logic [CW-1:0]  cur_cnt;
    logic [CW-1:0]  cnt_wr_val;
    logic           cnt_we;
    logic [CW-1:0]  flag_cnt;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [CW-1:0]  cnt_dec;

    assign cur_cnt = cmd_reg.sel ? odd_cnt_reg : even_cnt_reg;
    assign cnt_dec = cur_cnt - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;
        cnt_we          = 1'b0;
        cnt_wr_val      = cur_cnt;
        mem_we          = 1'b0;
        mem_waddr       = cur_cnt[AW-1:0];
        rd_en           = 1'b0;
        rd_addr         = cnt_dec[AW-1:0];
        flag_cnt        = cur_cnt;
        valid_next      = 1'b0;
        status_next     = STATUS_OK;
        stack_id_next   = cmd_reg.sel;
        data_next       = '0;
        data_valid_next = 1'b0;
        last_next       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                valid_next = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg.op)
                    CMD_PUSH:
                    begin
                        if (cur_cnt == CW'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            cnt_we     = 1'b1;
                            cnt_wr_val = cur_cnt + 1'b1;
                            flag_cnt   = cnt_wr_val;
                        end
                    end
                    CMD_POP:
                    begin
                        if (cur_cnt == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            valid_next = 1'b0;
                            cnt_we     = 1'b1;
                            cnt_wr_val = cnt_dec;
                            rd_en      = 1'b1;
                            state_next = ST_POP_OUT;
                        end
                    end
                    default:
                    begin
                        if (cur_cnt == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            valid_next = 1'b0;
                            rd_en      = 1'b1;
                            idx_next   = cnt_dec[AW-1:0];
                            state_next = ST_RD_STREAM;
                        end
                    end
                endcase
            end
            ST_POP_OUT:
            begin
                valid_next      = 1'b1;
                data_next       = rd_data_reg;
                data_valid_next = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_RD_STREAM:
            begin
                valid_next      = 1'b1;
                data_next       = rd_data_reg;
                data_valid_next = 1'b1;
                last_next       = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        is_empty_next = (flag_cnt == '0);
        is_full_next  = (flag_cnt == CW'(DEPTH));
    end

    always_comb
    begin
        even_cnt_next = even_cnt_reg;
        odd_cnt_next  = odd_cnt_reg;
        if (cnt_we)
        begin
            if (cmd_reg.sel)
            begin
                odd_cnt_next = cnt_wr_val;
            end
            else
            begin
                even_cnt_next = cnt_wr_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            even_cnt_reg <= '0;
            odd_cnt_reg  <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            even_cnt_reg <= even_cnt_next;
            odd_cnt_reg  <= odd_cnt_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        stack_id_reg   <= stack_id_next;
        data_reg       <= data_next;
        data_valid_reg <= data_valid_next;
        is_empty_reg   <= is_empty_next;
        is_full_reg    <= is_full_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (cmd_reg.sel)
            begin
                odd_mem_reg[mem_waddr] <= cmd_reg.value;
            end
            else
            begin
                even_mem_reg[mem_waddr] <= cmd_reg.value;
            end
        end
        if (rd_en)
        begin
            rd_data_reg <= cmd_reg.sel ? odd_mem_reg[rd_addr] : even_mem_reg[rd_addr];
        end
    end

    assign valid      = valid_reg;
    assign status     = status_reg;
    assign stack_id   = stack_id_reg;
    assign data       = data_reg;
    assign data_valid = data_valid_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;
    assign last       = last_reg;

`ifndef NO_ASSERTIONS
    a_data_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_valid_reg) |-> (data_reg == '0))
        else $error("data nonzero without data_valid");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == STATUS_EMPTY) |-> (is_empty_reg && last_reg))
        else $error("empty status without empty flag and last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (even_cnt_reg <= CW'(DEPTH)) && (odd_cnt_reg <= CW'(DEPTH)))
        else $error("stack count above depth");

    a_stream_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_STREAM && idx_reg != '0) |=> (state_reg == ST_RD_STREAM && valid_reg))
        else $error("read-out stopped early");
`endif

endmodule

// ===== test/parity_split_dual_stack_top_tb.sv =====
// Testbench: parity-split dual stack, directed and random commands checked against a scoreboard.
`timescale 1ns / 1ps

module parity_split_dual_stack_top_tb;

    import psds_pkg::*;

    localparam int         DEPTH     = DEPTH_DEFAULT;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] op;
        logic       sel;
        data_t      val;
        int         idle_before;
    } stack_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       stack_id;
        data_t      data;
        logic       data_valid;
        logic       is_empty;
        logic       is_full;
        logic       last;
    } stack_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] operation = OP_PUSH;
    logic       which_stack = 1'b0;
    data_t      value = '0;
    logic       busy;
    logic       valid;
    logic [1:0] status;
    logic       stack_id;
    data_t      data;
    logic       data_valid;
    logic       is_empty;
    logic       is_full;
    logic       last;

    stack_cmd_t    stack_cmds[$];
    stack_result_t stack_results_due[$];
    data_t         stack_mem[2][DEPTH];
    int            stack_count[2];
    int            error_count = 0;

    stack_cmd_t next_cmd;
    stack_cmd_t cur_cmd;
    logic       have_next = 1'b0;
    int         idle_cnt = 0;

    parity_split_dual_stack_top #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .which_stack(which_stack),
        .value      (value),
        .valid      (valid),
        .status     (status),
        .stack_id   (stack_id),
        .data       (data),
        .data_valid (data_valid),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .last       (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic predict_stack_op(input stack_cmd_t c);
        logic          sel;
        int            cnt;
        stack_result_t r;
        if (c.op == OP_UNUSED)
        begin
            return;
        end
        sel = (c.op == OP_PUSH) ? c.val[0] : c.sel;
        cnt = stack_count[sel];
        r = '0;
        r.stack_id = sel;
        r.last = 1'b1;
        if (c.op == OP_PUSH)
        begin
            if (cnt >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                stack_mem[sel][cnt] = c.val;
                cnt++;
                r.status = STATUS_OK;
            end
            r.is_empty = (cnt == 0);
            r.is_full = (cnt >= DEPTH);
            stack_results_due.push_back(r);
        end
        else if (cnt == 0)
        begin
            r.status = STATUS_EMPTY;
            r.is_empty = 1'b1;
            stack_results_due.push_back(r);
        end
        else if (c.op == OP_POP)
        begin
            cnt--;
            r.status = STATUS_OK;
            r.data = stack_mem[sel][cnt];
            r.data_valid = 1'b1;
            r.is_empty = (cnt == 0);
            r.is_full = 1'b0;
            stack_results_due.push_back(r);
        end
        else
        begin
            for (int i = cnt - 1; i >= 0; i--)
            begin
                r.status = STATUS_OK;
                r.data = stack_mem[sel][i];
                r.data_valid = 1'b1;
                r.is_empty = 1'b0;
                r.is_full = (cnt >= DEPTH);
                r.last = (i == 0);
                stack_results_due.push_back(r);
            end
        end
        stack_count[sel] = cnt;
    endtask

    // driver: one nonblocking write per signal per edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_stack_op(cur_cmd);
            end
            if (!(start && busy))
            begin
                if (!have_next && stack_cmds.size() != 0)
                begin
                    next_cmd = stack_cmds.pop_front();
                    have_next = 1'b1;
                    idle_cnt = next_cmd.idle_before;
                end
                if (idle_cnt > 0)
                begin
                    idle_cnt--;
                    start <= 1'b0;
                end
                else if (have_next)
                begin
                    cur_cmd = next_cmd;
                    have_next = 1'b0;
                    start <= 1'b1;
                    operation <= cur_cmd.op;
                    which_stack <= cur_cmd.sel;
                    value <= cur_cmd.val;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        stack_result_t act;
        stack_result_t exp_r;
        if (rst_n && valid)
        begin
            act = '{status, stack_id, data, data_valid, is_empty, is_full, last};
            if (stack_results_due.size() == 0)
            begin
                $display("%0t: unexpected, act st=%0d id=%0d d=%h dv=%0b e=%0b f=%0b l=%0b",
                         $time, act.status, act.stack_id, act.data, act.data_valid,
                         act.is_empty, act.is_full, act.last);
                error_count++;
            end
            else
            begin
                exp_r = stack_results_due.pop_front();
                if (act !== exp_r)
                begin
                    $display("%0t: mismatch exp st=%0d id=%0d d=%h dv=%0b e=%0b f=%0b l=%0b",
                             $time, exp_r.status, exp_r.stack_id, exp_r.data,
                             exp_r.data_valid, exp_r.is_empty, exp_r.is_full, exp_r.last);
                    $display("%0t:          act st=%0d id=%0d d=%h dv=%0b e=%0b f=%0b l=%0b",
                             $time, act.status, act.stack_id, act.data, act.data_valid,
                             act.is_empty, act.is_full, act.last);
                    error_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic add_cmd(input logic [1:0] op, input logic sel, input data_t val,
                           input int idle);
        stack_cmd_t c;
        c.op = op;
        c.sel = sel;
        c.val = val;
        c.idle_before = idle;
        stack_cmds.push_back(c);
    endtask

    initial
    begin
        int    counted;
        int    seg_len;
        int    mode;
        int    roll;
        int    push_w;
        int    pop_w;
        logic  target;
        logic  burst;
        logic  sel;
        logic [1:0] op;
        data_t val;

        for (int s = 0; s < 2; s++)
        begin
            stack_count[s] = 0;
        end

        // directed
        add_cmd(OP_POP,  1'b0, 32'h0000_0000, 0);
        add_cmd(OP_POP,  1'b1, 32'hFFFF_FFFF, 0);
        add_cmd(OP_READ, 1'b0, 32'h0000_0000, 2);
        add_cmd(OP_READ, 1'b1, 32'h0000_0000, 0);
        add_cmd(OP_PUSH, 1'b1, 32'h0000_0000, 0);
        add_cmd(OP_PUSH, 1'b0, 32'h8000_0000, 0);
        add_cmd(OP_PUSH, 1'b0, 32'h7FFF_FFFF, 1);
        add_cmd(OP_PUSH, 1'b1, 32'hFFFF_FFFF, 0);
        add_cmd(OP_PUSH, 1'b1, 32'h0000_0002, 0);
        add_cmd(OP_READ, 1'b0, 32'hFFFF_FFFF, 0);
        add_cmd(OP_READ, 1'b1, 32'h0000_0000, 0);
        add_cmd(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 0);
        add_cmd(OP_UNUSED, 1'b0, 32'h0000_0000, 0);
        add_cmd(OP_POP,  1'b1, 32'h5555_5555, 0);
        add_cmd(OP_POP,  1'b1, 32'hAAAA_AAAA, 3);
        add_cmd(OP_POP,  1'b1, 32'h0000_0000, 0);
        add_cmd(OP_POP,  1'b0, 32'h0000_0000, 0);
        add_cmd(OP_READ, 1'b0, 32'h0000_0000, 0);
        add_cmd(OP_POP,  1'b0, 32'h0000_0000, 0);
        add_cmd(OP_POP,  1'b0, 32'h0000_0000, 0);
        add_cmd(OP_READ, 1'b0, 32'h0000_0000, 0);

        // random segments: fill, drain or mixed, steered toward one stack
        counted = 0;
        while (counted < 80)
        begin
            mode = $urandom_range(0, 2);
            target = 1'($urandom_range(0, 1));
            burst = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(20, 40);
            push_w = (mode == 0) ? 85 : (mode == 1) ? 10 : 40;
            pop_w = (mode == 0) ? 5 : (mode == 1) ? 80 : 40;
            for (int k = 0; k < seg_len && counted < 80; k++)
            begin
                val = $urandom;
                sel = ($urandom_range(0, 99) < 80) ? target : ~target;
                if ($urandom_range(0, 99) < 4)
                begin
                    op = OP_UNUSED;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_w)
                    begin
                        op = OP_PUSH;
                        if ($urandom_range(0, 99) < 85)
                        begin
                            val[0] = target;
                        end
                    end
                    else if (roll < push_w + pop_w)
                    begin
                        op = OP_POP;
                    end
                    else
                    begin
                        op = OP_READ;
                    end
                    counted++;
                end
                add_cmd(op, sel, val, burst ? 0 : pick_gap());
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (stack_cmds.size() != 0 || have_next || start)
        begin
            @(posedge clk);
        end
        while (stack_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
